// ===== rtl/sitp_pkg.sv =====
// ============================================================================
// sitp_pkg
// Shared types and constants for the signed integer to padded decimal block.
// ============================================================================
package sitp_pkg;

   // Widths of the item fields
   localparam int VAL_W   = 32;
   localparam int CHAR_W  = 6;
   localparam int WIDTH_W = 6;

   // Widest padded field (digits plus spaces) that the block produces
   localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(32);

   // BCD conversion sizing: ten digits cover the 32-bit magnitude
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
   localparam int STEP_W     = $clog2(VAL_W);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);
   localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);

   // Classified item handed from front to back
   typedef struct packed {
      logic             neg;
      logic [VAL_W-1:0] mag;
   } item_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      B_IDLE,
      B_CONV,
      B_SIZE,
      B_EMIT
   } back_state_type;

endpackage

// ===== rtl/sitp_front.sv =====
// ============================================================================
// sitp_front
// Input stage: takes an item, splits it into sign and unsigned magnitude.
// ============================================================================
module sitp_front
   import sitp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [VAL_W-1:0] req_value,
   output logic             push,
   output item_type         push_item,
   input  logic             q_full
);

   logic     front_valid_ff, front_valid_in;
   item_type front_item_ff, front_item_in;
   logic     accept;

   // Handshake: hold off only when the stage is full and cannot drain
   assign req_stall = front_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !q_full;
   assign push_item = front_item_ff;

   // Classify: sign bit and two's complement magnitude (exact for the minimum)
   always_comb begin
      front_item_in.neg = req_value[VAL_W-1];
      front_item_in.mag = req_value[VAL_W-1] ? (VAL_W'(0) - req_value) : req_value;
      front_valid_in    = accept || (front_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

// ===== rtl/sitp_queue.sv =====
// ============================================================================
// sitp_queue
// Short FIFO that decouples the classify stage from the conversion engine.
// ============================================================================
module sitp_queue
   import sitp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     q_full,
   input  logic     pop,
   output logic     q_valid,
   output item_type q_item
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/sitp_back.sv =====
// ============================================================================
// sitp_back
// Conversion engine: shift-add-3 binary to BCD, sizing, then one character
// per cycle into the result register while rsp_stall does not hold it.
// ============================================================================
module sitp_back
   import sitp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [WIDTH_W-1:0] min_width,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_last
);

   back_state_type       state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [VAL_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 sign_ff, sign_in;
   logic [WIDTH_W-1:0]   pad_ff, pad_in;
   logic [DIG_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;

   logic [BCD_W-1:0]     bcd_adj;
   logic [3:0]           cur_digit;
   logic [DIG_IDX_W:0]   num_digits;
   logic [WIDTH_W-1:0]   width_sat;
   logic                 out_free;
   logic                 final_char;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur_digit  = bcd_ff[4*idx_ff +: 4];
   assign final_char = !sign_ff && (pad_ff == '0) && (idx_ff == '0);
   assign width_sat  = (min_width > MAX_WIDTH) ? MAX_WIDTH : min_width;

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   // Number of significant digits, at least one
   always_comb begin
      num_digits = (DIG_IDX_W + 1)'(1);
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            num_digits = (DIG_IDX_W + 1)'(i + 1);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               state_in = B_CONV;
            end
         end
         B_CONV: begin
            if (step_ff == STEP_W'(VAL_W - 1)) begin
               state_in = B_SIZE;
            end
         end
         B_SIZE: begin
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free && final_char) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pop          = 1'b0;
      neg_in       = neg_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      sign_in      = sign_ff;
      pad_in       = pad_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               neg_in  = q_item.neg;
               bin_in  = q_item.mag;
               bcd_in  = '0;
               step_in = '0;
            end
         end
         B_CONV: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[VAL_W-1]};
            bin_in  = {bin_ff[VAL_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
         end
         B_SIZE: begin
            sign_in = neg_ff;
            idx_in  = DIG_IDX_W'(num_digits - 1'b1);
            pad_in  = (width_sat > WIDTH_W'(num_digits))
                      ? width_sat - WIDTH_W'(num_digits) : '0;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  char_in = CH_MINUS;
                  last_in = 1'b0;
                  sign_in = 1'b0;
               end else if (pad_ff != '0) begin
                  char_in = CH_SPACE;
                  last_in = 1'b0;
                  pad_in  = pad_ff - 1'b1;
               end else begin
                  char_in = CH_ZERO + CHAR_W'(cur_digit);
                  last_in = (idx_ff == '0);
                  if (idx_ff != '0) begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      sign_ff <= sign_in;
      pad_ff  <= pad_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

// ===== rtl/signed_int_to_padded_decimal.sv =====
// ============================================================================
// signed_int_to_padded_decimal
// Converts a signed 32-bit integer to decimal ASCII, one character per item:
// optional minus, space padding up to min_width, then the digits.
// ============================================================================
//
//   port group   dir   handshake            payload
//   req_         in    req_valid/req_stall  req_value[31:0] signed
//   rsp_         out   rsp_valid/rsp_stall  rsp_char_out[5:0], rsp_last
//   csr_         in    csr_wr_en            csr_wr_data[5:0] (min_width)
//
// Each item passes through the conversion engine (queue pop, 32 shift-add-3
// steps, sizing) and then emits 1 to 33 characters, one per cycle while
// rsp_stall is low. The BCD loop shifts in one bit per cycle.
// A two-entry queue lets the input side accept the next items while the engine is busy.
// Synchronous active-high reset clears all control state; min_width resets to 0.
// rsp_stall holds the result register; the engine waits behind it.
//
module signed_int_to_padded_decimal
   import sitp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VAL_W-1:0]   req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [WIDTH_W-1:0] csr_wr_data
);

   logic [WIDTH_W-1:0] min_width_ff, min_width_in;
   logic               push;
   item_type           push_item;
   logic               q_full;
   logic               pop;
   logic               q_valid;
   item_type           q_item;

   // Width register
   assign min_width_in = csr_wr_en ? csr_wr_data : min_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= '0;
      end else begin
         min_width_ff <= min_width_in;
      end
   end

   sitp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   sitp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   sitp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_width    (min_width_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== rtl/sitp_checker.sv =====
// ============================================================================
// sitp_checker
// Port-level checks on the result channel of the decimal converter.
// ============================================================================
module sitp_checker
   import sitp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [CHAR_W-1:0]  rsp_char_out,
   input logic               rsp_last
);

   // Result register empties on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_char_out)
                                    && $stable(rsp_last)))
      else $error("stalled result changed");

   // Only space, minus or digit codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out == CH_SPACE || rsp_char_out == CH_MINUS
                     || (rsp_char_out >= CH_ZERO && rsp_char_out <= CH_ZERO + 6'd9)))
      else $error("illegal character code");

   // Text always ends on a digit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_char_out >= CH_ZERO
                                   && rsp_char_out <= CH_ZERO + 6'd9))
      else $error("last flag on a non-digit");

   // Minus sign only opens a number
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_char_out >= CH_ZERO) ##1 rsp_valid
      |-> (rsp_char_out != CH_MINUS || $past(rsp_last)))
      else $error("minus sign inside a number");

endmodule

bind signed_int_to_padded_decimal sitp_checker u_sitp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

// ===== bench/sitp_text_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sitp_text_checker
// Watches the request, response and CSR ports of the signed integer to padded
// decimal block. Spells out each accepted value as the expected characters
// and compares every accepted response character against the oldest one.
// ============================================================================
module sitp_text_checker
   import sitp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [VAL_W-1:0]   req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [CHAR_W-1:0]  rsp_char_out,
   input  logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [WIDTH_W-1:0] csr_wr_data,
   output int                 fail_count,
   output int                 outstanding
);

   localparam int DIGIT_SLOTS = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   text_char_type      expected_text[$];
   logic [WIDTH_W-1:0] min_width = '0;
   int                 errors = 0;

   // Append the characters of one value: sign, padding, digits MSD first
   function automatic void spell_value(input logic [VAL_W-1:0] value);
      logic [3:0]       digit_buf [DIGIT_SLOTS];
      logic [VAL_W-1:0] mag;
      logic             neg;
      int               nd;
      int               field;
      int               pad;
      int               total;
      int               k;
      text_char_type    c;
      neg = value[VAL_W-1];
      mag = neg ? (~value + 1'b1) : value;
      nd  = 0;
      do begin
         digit_buf[nd] = 4'(mag % 10);
         mag = mag / 10;
         nd++;
      end while (mag != 0 && nd < DIGIT_SLOTS);
      // register value saturates at the widest field
      field = (min_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(min_width);
      pad   = (field > nd) ? field - nd : 0;
      total = (neg ? 1 : 0) + pad + nd;
      k     = 0;
      if (neg) begin
         c.code = CH_MINUS;
         c.last = (k + 1 == total);
         expected_text.push_back(c);
         k++;
      end
      for (int i = 0; i < pad; i++) begin
         c.code = CH_SPACE;
         c.last = (k + 1 == total);
         expected_text.push_back(c);
         k++;
      end
      for (int i = nd - 1; i >= 0; i--) begin
         c.code = CH_ZERO + CHAR_W'(digit_buf[i]);
         c.last = (k + 1 == total);
         expected_text.push_back(c);
         k++;
      end
   endfunction

   // Track the register, predict on each request item, check each response item
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         min_width = '0;
      end else begin
         if (csr_wr_en)
            min_width = csr_wr_data;
         if (req_valid && !req_stall)
            spell_value(req_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected char: expected none, actual %0d last %0b",
                        $time, rsp_char_out, rsp_last);
               errors++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_out !== want.code) begin
                  $display("%0t: char mismatch: expected %0d, actual %0d",
                           $time, want.code, rsp_char_out);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_text.size();
   end

endmodule

// ===== bench/tb_signed_int_to_padded_decimal.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_signed_int_to_padded_decimal
// Drives signed values into the decimal text block under several min_width
// settings and idle/stall mixes, including a long response hold-off that
// backs the block up; the checker predicts and compares every character.
// ============================================================================
module tb_signed_int_to_padded_decimal
   import sitp_pkg::*;
();

   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 600;
   localparam int PHASE_ITEMS   = 25;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [VAL_W-1:0]   req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [CHAR_W-1:0]  rsp_char_out;
   logic               rsp_last;
   logic               csr_wr_en;
   logic [WIDTH_W-1:0] csr_wr_data;
   int                 fail_count;
   int                 outstanding;
   int                 send_pct = 0;
   int                 stall_pct = 0;
   logic               hold_request = 1'b0;
   logic               hold_served = 1'b0;

   signed_int_to_padded_decimal dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   sitp_text_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("tb_signed_int_to_padded_decimal: FAIL");
      $finish;
   end

   // Response side: random stall, or one long hold-off when requested
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Offer one item after random idle cycles; returns at the accepting edge
   task automatic send_item(input logic [VAL_W-1:0] value);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stop offering, wait for every character, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_width(input logic [WIDTH_W-1:0] width);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= width;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of full-range, short, decade-edge and extreme values
   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] v;
      logic [VAL_W-1:0] decade;
      int               k;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 99999);
         2: begin
            decade = 1;
            k = $urandom_range(0, 9);
            repeat (k) decade = decade * 10;
            v = decade - VAL_W'($urandom_range(0, 1));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = '0;
               default: v = '1;
            endcase
         end
      endcase
      if ($urandom_range(0, 1) && v != 32'h8000_0000)
         v = ~v + 1'b1;
      return v;
   endfunction

   task automatic random_phase(input logic [WIDTH_W-1:0] width, input int idle_pct,
                               input int stall_mix);
      program_width(width);
      send_pct   = idle_pct;
      stall_pct <= stall_mix;
      repeat (PHASE_ITEMS) send_item(pick_value());
      drain();
   endtask

   // Stimulus and verdict
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_value   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // no padding: zero, minus one, both extremes and nine
      program_width(6'd0);
      send_item(32'd0);
      send_item(32'hFFFF_FFFF);
      send_item(32'h7FFF_FFFF);
      send_item(32'h8000_0000);
      send_item(32'd9);
      drain();

      // register above the widest field saturates
      program_width(6'd63);
      send_item(32'd0);
      send_item(32'h8000_0000);
      send_item(32'd123);
      drain();

      // width equal to and one above the digit count
      program_width(6'd10);
      send_item(32'd1_000_000_000);
      send_item(32'(-999_999_999));
      send_item(32'(-5));
      send_item(32'd42);
      drain();

      // widest field exactly
      program_width(MAX_WIDTH);
      send_item(32'hFFFF_FFFF);
      send_item(32'd7);
      drain();

      // random values under several widths and flow-control mixes
      random_phase(WIDTH_W'($urandom_range(0, 12)), 0, 0);
      random_phase(MAX_WIDTH, 87, 0);
      random_phase(WIDTH_W'($urandom_range(13, 63)), 0, 87);
      random_phase(WIDTH_W'($urandom_range(0, 63)), 10, 10);

      // long response hold-off while requests keep coming
      program_width(6'd20);
      send_pct      = 0;
      stall_pct    <= 0;
      hold_request <= 1'b1;
      repeat (8) send_item(pick_value());
      drain();

      if (fail_count == 0 && outstanding == 0)
         $display("tb_signed_int_to_padded_decimal: PASS");
      else
         $display("tb_signed_int_to_padded_decimal: FAIL");
      $finish;
   end

endmodule
